// ----- sv/assert_macros.svh -----
// Assertion helpers used by the parser RTL.
// Each use expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, except while rst is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check prop at every rising edge of clk, including during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/ihex_pkg.sv -----
// ----------------------------------------------------------------------------
// ihex_pkg
// Codes, character constants and the hex digit decoder for the record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

   localparam int PHASE_W = 4;
   localparam int KIND_W  = 3;

   typedef logic [PHASE_W-1:0] phase_type;
   typedef logic [KIND_W-1:0]  kind_type;

   localparam phase_type PH_LINE_START = 4'd0;
   localparam phase_type PH_SKIP       = 4'd1;
   localparam phase_type PH_COUNT      = 4'd2;
   localparam phase_type PH_ADDR_HI    = 4'd3;
   localparam phase_type PH_ADDR_LO    = 4'd4;
   localparam phase_type PH_TYPE       = 4'd5;
   localparam phase_type PH_DATA       = 4'd6;
   localparam phase_type PH_CSUM       = 4'd7;
   localparam phase_type PH_DONE       = 4'd8;

   localparam kind_type KIND_HEADER   = 3'd0;
   localparam kind_type KIND_DATA     = 3'd1;
   localparam kind_type KIND_OK       = 3'd2;
   localparam kind_type KIND_BADSUM   = 3'd3;
   localparam kind_type KIND_BADDIGIT = 3'd4;
   localparam kind_type KIND_TRUNC    = 3'd5;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_DIG_0   = 8'h30;
   localparam logic [7:0] CH_DIG_9   = 8'h39;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_F   = 8'h66;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_F    = 8'h46;

   typedef struct packed {
      logic       bad;
      logic [3:0] value;
   } digit_type;

   // Decode one ASCII hex digit; flag anything else as bad.
   function automatic digit_type hex_digit(input logic [7:0] c);
      digit_type d;
      logic [7:0] t;
      d.bad   = 1'b0;
      d.value = 4'd0;
      t       = 8'd0;
      if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
         t       = c - CH_DIG_0;
         d.value = t[3:0];
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
         t       = c - CH_LOW_A + 8'd10;
         d.value = t[3:0];
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         t       = c - CH_UP_A + 8'd10;
         d.value = t[3:0];
      end else begin
         d.bad = 1'b1;
      end
      return d;
   endfunction

endpackage

// ----- sv/intel_hex_record_parser_top.sv -----
// ----------------------------------------------------------------------------
// intel_hex_record_parser_top
// Parses a character stream into Intel HEX header, data and status results.
// ----------------------------------------------------------------------------
//   Channel | Ports                         | Direction
//   req     | req_valid/ready, char_code    | in, one character per transaction
//   rsp     | rsp_valid/ready, six fields   | out, zero or one per character
//
// One character per cycle while rsp is not stalled; each character waits in the
// input register and is parsed as it moves into the result register.
// Parse state updates in that single step (phase, nibble, sum, record fields).
// Characters that give no result pass through without occupying the output.
// A stalled rsp holds its result; req keeps accepting while the input register
// can drain. Synchronous reset returns to waiting for a line start.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module intel_hex_record_parser_top
   import ihex_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_kind,
   output logic [15:0] rsp_record_address,
   output logic [7:0]  rsp_record_type,
   output logic [7:0]  rsp_byte_count,
   output logic [7:0]  rsp_data_value,
   output logic [7:0]  rsp_data_index
);

   // input register
   logic        in_vld_ff, in_vld_in;
   logic [7:0]  char_ff, char_in;

   // parse state
   phase_type   phase_ff, phase_in;
   logic        pend_ff, pend_in;
   logic [3:0]  high_ff, high_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  seen_ff, seen_in;

   // result register
   logic        out_vld_ff, out_vld_in;
   kind_type    kind_ff, kind_in;
   logic [15:0] raddr_ff, raddr_in;
   logic [7:0]  rtype_ff, rtype_in;
   logic [7:0]  rcount_ff, rcount_in;
   logic [7:0]  dval_ff, dval_in;
   logic [7:0]  didx_ff, didx_in;

   logic        fire;
   logic        has_res;
   logic        rec_fields;
   kind_type    kind_new;
   digit_type   dig;
   logic [7:0]  byte_val;
   logic [7:0]  sum_next;
   logic [7:0]  seen_next;

   assign fire      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;
   assign dig       = hex_digit(char_ff);
   assign byte_val  = {high_ff, dig.value};
   assign sum_next  = sum_ff + byte_val;
   assign seen_next = seen_ff + 8'd1;

   always_comb begin
      in_vld_in  = in_vld_ff;
      char_in    = char_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
         char_in   = req_char_code;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      pend_in    = pend_ff;
      high_in    = high_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      addr_in    = addr_ff;
      type_in    = type_ff;
      seen_in    = seen_ff;
      has_res    = 1'b0;
      rec_fields = 1'b0;
      kind_new   = KIND_HEADER;
      dval_in    = 8'd0;
      didx_in    = 8'd0;
      if (fire) begin
         priority if (phase_ff == PH_LINE_START) begin
            if (char_ff == CH_COLON) begin
               sum_in   = 8'd0;
               pend_in  = 1'b0;
               high_in  = 4'd0;
               count_in = 8'd0;
               addr_in  = 16'd0;
               type_in  = 8'd0;
               seen_in  = 8'd0;
               phase_in = PH_COUNT;
            end else if (char_ff != CH_NEWLINE) begin
               phase_in = PH_SKIP;
            end
         end else if (phase_ff < PH_COUNT || phase_ff > PH_CSUM) begin
            if (char_ff == CH_NEWLINE) begin
               phase_in = PH_LINE_START;
            end else if (phase_ff != PH_DONE) begin
               phase_in = PH_SKIP;
            end
         end else if (char_ff == CH_NEWLINE) begin
            pend_in  = 1'b0;
            phase_in = PH_LINE_START;
            has_res  = 1'b1;
            kind_new = KIND_TRUNC;
         end else if (dig.bad) begin
            pend_in  = 1'b0;
            phase_in = PH_SKIP;
            has_res  = 1'b1;
            kind_new = KIND_BADDIGIT;
         end else if (!pend_ff) begin
            high_in = dig.value;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
            sum_in  = sum_next;
            unique case (phase_ff)
               PH_COUNT: begin
                  count_in = byte_val;
                  phase_in = PH_ADDR_HI;
               end
               PH_ADDR_HI: begin
                  addr_in  = {byte_val, 8'd0};
                  phase_in = PH_ADDR_LO;
               end
               PH_ADDR_LO: begin
                  addr_in  = addr_ff | {8'd0, byte_val};
                  phase_in = PH_TYPE;
               end
               PH_TYPE: begin
                  type_in    = byte_val;
                  phase_in   = (count_ff != 8'd0) ? PH_DATA : PH_CSUM;
                  has_res    = 1'b1;
                  rec_fields = 1'b1;
                  kind_new   = KIND_HEADER;
               end
               PH_DATA: begin
                  has_res    = 1'b1;
                  rec_fields = 1'b1;
                  kind_new   = KIND_DATA;
                  dval_in    = byte_val;
                  didx_in    = seen_ff;
                  seen_in    = seen_next;
                  if (seen_next == count_ff) begin
                     phase_in = PH_CSUM;
                  end
               end
               default: begin
                  phase_in   = PH_DONE;
                  has_res    = 1'b1;
                  rec_fields = 1'b1;
                  kind_new   = (sum_next == 8'd0) ? KIND_OK : KIND_BADSUM;
               end
            endcase
         end
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff && !rsp_ready;
      kind_in    = kind_ff;
      raddr_in   = raddr_ff;
      rtype_in   = rtype_ff;
      rcount_in  = rcount_ff;
      if (fire) begin
         out_vld_in = has_res;
         kind_in    = kind_new;
         raddr_in   = rec_fields ? addr_in  : 16'd0;
         rtype_in   = rec_fields ? type_in  : 8'd0;
         rcount_in  = rec_fields ? count_in : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= PH_LINE_START;
         pend_ff    <= 1'b0;
         seen_ff    <= 8'd0;
         count_ff   <= 8'd0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         phase_ff   <= phase_in;
         pend_ff    <= pend_in;
         seen_ff    <= seen_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      high_ff   <= high_in;
      sum_ff    <= sum_in;
      addr_ff   <= addr_in;
      type_ff   <= type_in;
      kind_ff   <= kind_in;
      raddr_ff  <= raddr_in;
      rtype_ff  <= rtype_in;
      rcount_ff <= rcount_in;
      if (fire) begin
         dval_ff <= dval_in;
         didx_ff <= didx_in;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_record_address = raddr_ff;
   assign rsp_record_type    = rtype_ff;
   assign rsp_byte_count     = rcount_ff;
   assign rsp_data_value     = dval_ff;
   assign rsp_data_index     = didx_ff;

   `ASSERT_CLK(a_phase_range, clock, reset, phase_ff <= PH_DONE, "parse phase out of range")
   `ASSERT_CLK(a_data_bound, clock, reset, (phase_ff == PH_DATA) |-> (seen_ff < count_ff), "data index passed declared count")
   `ASSERT_CLK(a_err_zero, clock, reset, (out_vld_ff && (kind_ff == KIND_BADDIGIT || kind_ff == KIND_TRUNC)) |-> (raddr_ff == 16'd0 && rtype_ff == 8'd0 && rcount_ff == 8'd0), "error result carries record fields")
   `ASSERT_CLK(a_nondata_zero, clock, reset, (out_vld_ff && kind_ff != KIND_DATA) |-> (dval_ff == 8'd0 && didx_ff == 8'd0), "data fields set outside a data result")
   `ASSERT_CLK(a_stall_cause, clock, reset, !req_ready |-> (in_vld_ff && out_vld_ff && !rsp_ready), "input stalled without a blocked output")

endmodule

// ----- test/intel_hex_record_parser_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// intel_hex_record_parser_top_tb
// Feeds character lines to the record parser and checks every header, data
// byte and status result against a cycle-free parser model kept in this bench.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_top_tb;
   import ihex_pkg::*;

   localparam int         CYCLE_LIMIT = 400000;
   localparam int         HOLD_CYCLES = 200;
   localparam int         PHASE_CHARS = 200;
   localparam logic [7:0] CH_CR       = 8'h0D;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  rtype;
      logic [7:0]  count;
      logic [7:0]  value;
      logic [7:0]  index;
   } hex_result_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [2:0]  rsp_result_kind;
   logic [15:0] rsp_record_address;
   logic [7:0]  rsp_record_type;
   logic [7:0]  rsp_byte_count;
   logic [7:0]  rsp_data_value;
   logic [7:0]  rsp_data_index;

   // parser model state
   phase_type   cur_phase;
   logic        half_pending;
   logic [3:0]  upper_nib;
   logic [7:0]  byte_sum;
   logic [7:0]  rec_count;
   logic [15:0] rec_addr;
   logic [7:0]  rec_type;
   logic [7:0]  data_seen;

   hex_result_type pending_results[$];
   logic [7:0]     line_chars[$];

   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int unsigned hold_seq      = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;
   int unsigned chars_sent    = 0;
   int unsigned cycle_count   = 0;
   int          fail_count    = 0;

   intel_hex_record_parser_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_record_address (rsp_record_address),
      .rsp_record_type    (rsp_record_type),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_data_value     (rsp_data_value),
      .rsp_data_index     (rsp_data_index)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("intel_hex_record_parser_top test failed");
         $finish;
      end
   end

   // Receiver: a requested hold wins over the random stall.
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      hex_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("rsp: transaction with no result expected, result_kind %0d",
                   rsp_result_kind);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_result_kind);
               fail_count++;
            end
            if (rsp_record_address !== want.address) begin
               $error("record_address: expected %h, got %h", want.address,
                      rsp_record_address);
               fail_count++;
            end
            if (rsp_record_type !== want.rtype) begin
               $error("record_type: expected %h, got %h", want.rtype, rsp_record_type);
               fail_count++;
            end
            if (rsp_byte_count !== want.count) begin
               $error("byte_count: expected %h, got %h", want.count, rsp_byte_count);
               fail_count++;
            end
            if (rsp_data_value !== want.value) begin
               $error("data_value: expected %h, got %h", want.value, rsp_data_value);
               fail_count++;
            end
            if (rsp_data_index !== want.index) begin
               $error("data_index: expected %h, got %h", want.index, rsp_data_index);
               fail_count++;
            end
         end
      end
   end

   // 0..15 for a hex digit, 16 for anything else
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      if (c >= CH_DIG_0 && c <= CH_DIG_9) return 5'(c - CH_DIG_0);
      if (c >= CH_LOW_A && c <= CH_LOW_F) return 5'(c - CH_LOW_A + 8'd10);
      if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
      return 5'd16;
   endfunction

   function automatic void clear_parser_model();
      cur_phase    = PH_LINE_START;
      half_pending = 1'b0;
      upper_nib    = 4'd0;
      byte_sum     = 8'd0;
      rec_count    = 8'd0;
      rec_addr     = 16'd0;
      rec_type     = 8'd0;
      data_seen    = 8'd0;
   endfunction

   function automatic hex_result_type record_result(input kind_type kind);
      hex_result_type r;
      r         = '0;
      r.kind    = kind;
      r.address = rec_addr;
      r.rtype   = rec_type;
      r.count   = rec_count;
      return r;
   endfunction

   function automatic void predict_char(input logic [7:0] c);
      hex_result_type r;
      logic [4:0]     dv;
      logic [7:0]     b;
      r = '0;
      if (cur_phase == PH_LINE_START) begin
         if (c == CH_COLON) begin
            clear_parser_model();
            cur_phase = PH_COUNT;
         end else if (c != CH_NEWLINE) begin
            cur_phase = PH_SKIP;
         end
         return;
      end
      // skipping a line, or past the checksum
      if (cur_phase < PH_COUNT || cur_phase > PH_CSUM) begin
         if (c == CH_NEWLINE) cur_phase = PH_LINE_START;
         else if (cur_phase != PH_DONE) cur_phase = PH_SKIP;
         return;
      end
      if (c == CH_NEWLINE) begin
         half_pending = 1'b0;
         cur_phase    = PH_LINE_START;
         r.kind       = KIND_TRUNC;
         pending_results.push_back(r);
         return;
      end
      dv = hex_value(c);
      if (dv[4]) begin
         half_pending = 1'b0;
         cur_phase    = PH_SKIP;
         r.kind       = KIND_BADDIGIT;
         pending_results.push_back(r);
         return;
      end
      if (!half_pending) begin
         upper_nib    = dv[3:0];
         half_pending = 1'b1;
         return;
      end
      half_pending = 1'b0;
      b            = {upper_nib, dv[3:0]};
      byte_sum     = byte_sum + b;
      case (cur_phase)
         PH_COUNT: begin
            rec_count = b;
            cur_phase = PH_ADDR_HI;
         end
         PH_ADDR_HI: begin
            rec_addr  = {b, 8'd0};
            cur_phase = PH_ADDR_LO;
         end
         PH_ADDR_LO: begin
            rec_addr[7:0] = b;
            cur_phase     = PH_TYPE;
         end
         PH_TYPE: begin
            rec_type  = b;
            cur_phase = (rec_count != 0) ? PH_DATA : PH_CSUM;
            pending_results.push_back(record_result(KIND_HEADER));
         end
         PH_DATA: begin
            r         = record_result(KIND_DATA);
            r.value   = b;
            r.index   = data_seen;
            data_seen = data_seen + 8'd1;
            if (data_seen == rec_count) cur_phase = PH_CSUM;
            pending_results.push_back(r);
         end
         default: begin
            cur_phase = PH_DONE;
            pending_results.push_back(record_result(byte_sum == 0 ? KIND_OK : KIND_BADSUM));
         end
      endcase
   endfunction

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      predict_char(c);
      chars_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_line();
      foreach (line_chars[i]) send_char(line_chars[i]);
      line_chars.delete();
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct <= stall_pct;
   endtask

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
   endfunction

   // Two digits, high nibble first, letters in random case.
   function automatic void push_hex_byte(input logic [7:0] b);
      logic [3:0] n;
      logic [7:0] base;
      for (int k = 1; k >= 0; k--) begin
         n    = (k == 1) ? b[7:4] : b[3:0];
         base = $urandom_range(1) ? CH_UP_A : CH_LOW_A;
         line_chars.push_back((n < 4'd10) ? CH_DIG_0 + 8'(n) : base + 8'(n) - 8'd10);
      end
   endfunction

   function automatic void build_record(input int count, input bit good_sum);
      logic [7:0]  sum;
      logic [7:0]  b;
      logic [15:0] addr;
      addr = 16'($urandom);
      line_chars.push_back(CH_COLON);
      sum = 8'(count);
      push_hex_byte(8'(count));
      push_hex_byte(addr[15:8]);
      sum += addr[15:8];
      push_hex_byte(addr[7:0]);
      sum += addr[7:0];
      for (int i = -1; i < count; i++) begin
         b = 8'($urandom);
         push_hex_byte(b);
         sum += b;
      end
      push_hex_byte(good_sum ? ~sum + 8'd1 : 8'($urandom));
   endfunction

   // Mostly short records, now and then a long one.
   function automatic int pick_record_count();
      int r;
      r = $urandom_range(99);
      if (r < 88) return $urandom_range(0, 8);
      if (r < 98) return $urandom_range(9, 40);
      return $urandom_range(41, 255);
   endfunction

   function automatic logic [7:0] pick_plain_char();
      logic [7:0] c;
      do c = 8'($urandom); while (c == CH_NEWLINE);
      return c;
   endfunction

   function automatic logic [7:0] pick_bad_char();
      logic [7:0] c;
      logic [4:0] v;
      do begin
         c = 8'($urandom);
         v = hex_value(c);
      end while (c == CH_NEWLINE || v < 5'd16);
      return c;
   endfunction

   task automatic send_random_line();
      int r;
      int cut;
      r = $urandom_range(99);
      if (r < 90) begin
         build_record(pick_record_count(), $urandom_range(99) >= 15);
         if (r >= 80) begin
            cut             = $urandom_range(1, line_chars.size() - 1);
            line_chars[cut] = pick_bad_char();
         end else if (r >= 70) begin
            // drop the tail so the newline lands before the checksum is complete
            cut = $urandom_range(1, line_chars.size() - 1);
            while (line_chars.size() > cut) void'(line_chars.pop_back());
         end else if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 4)) line_chars.push_back(pick_plain_char());
         end
      end else begin
         repeat ($urandom_range(0, 12)) line_chars.push_back(pick_plain_char());
      end
      line_chars.push_back(CH_NEWLINE);
      send_line();
   endtask

   task automatic test_directed_lines();
      set_idling(0, 0);
      // zero count, top address: checksum follows the type byte
      push_text(":00FFFF0101");
      line_chars.push_back(CH_NEWLINE);
      line_chars.push_back(CH_NEWLINE);
      // non-record line with the extreme character codes
      line_chars.push_back(8'hFF);
      line_chars.push_back(8'h00);
      line_chars.push_back(CH_NEWLINE);
      // carriage return where a digit is expected
      push_text(":");
      line_chars.push_back(CH_CR);
      line_chars.push_back(CH_NEWLINE);
      push_text(":0");
      line_chars.push_back(CH_NEWLINE);
      send_line();
      wait_results_drained();
   endtask

   task automatic test_long_record();
      set_idling(0, 38);
      build_record(255, 1'b1);
      line_chars.push_back(CH_NEWLINE);
      send_line();
      wait_results_drained();
   endtask

   task automatic test_random_lines(input int send_pct, input int stall_pct);
      int unsigned start;
      set_idling(send_pct, stall_pct);
      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) send_random_line();
   endtask

   // Hold off the receiver while records keep coming, then drain.
   task automatic test_output_backpressure();
      set_idling(0, 0);
      hold_seq <= hold_seq + 1;
      repeat (4) begin
         build_record(8, 1'b1);
         line_chars.push_back(CH_NEWLINE);
         send_line();
      end
      wait_results_drained();
   endtask

   initial begin
      clear_parser_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_lines();
      test_long_record();
      test_random_lines(0, 0);
      test_random_lines(72, 0);
      test_random_lines(0, 72);
      test_random_lines(38, 38);
      test_output_backpressure();
      wait_results_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("intel_hex_record_parser_top test passed");
      end else begin
         $display("intel_hex_record_parser_top test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/ihex_pkg.sv
sv/intel_hex_record_parser_top.sv
test/intel_hex_record_parser_top_tb.sv
